// File: rtl/mar_pkg.sv
// Shared constants and types for the moving average / rms envelope block.
package mar_pkg;

   localparam int MAX_WINDOW   = 256;
   localparam int IDX_W        = $clog2(MAX_WINDOW);
   localparam int WLEN_W       = $clog2(MAX_WINDOW + 1);
   localparam int RESET_WINDOW = 100;
   localparam int RESET_WLEN   = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

   localparam int SAMPLE_W  = 16;
   localparam int OUT_W     = 17;
   localparam int VAL_W     = 32;
   localparam int OUT_LIMIT = 32768;

   localparam int SUM_W       = VAL_W + IDX_W;
   localparam int DIV_W       = SUM_W + (SUM_W % 2);
   localparam int DIV_STEPS   = DIV_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   // mean of in-range values never exceeds 2^30
   localparam int SQ_IN_W  = 32;
   localparam int SQ_RT_W  = SQ_IN_W / 2;
   localparam int SQ_REM_W = SQ_RT_W + 1;
   localparam int SQ_CNT_W = $clog2(SQ_RT_W + 1);

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;
   localparam int MODE_W     = 2;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_AVERAGE_MODE  = CSR_IDX_W'(1);

   typedef enum logic [MODE_W-1:0] {
      MODE_BIPOLAR  = 2'd0,
      MODE_ABSOLUTE = 2'd1,
      MODE_RMS      = 2'd2
   } mode_type;

endpackage

// File: rtl/mar_if.sv
// Request, response and register-write channel interfaces.
interface mar_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mar_pkg::SAMPLE_W-1:0]    sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mar_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mar_pkg::OUT_W-1:0]       average_value;
   modport source (output valid, output average_value, input ready);
   modport sink   (input valid, input average_value, output ready);
endinterface

interface mar_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [mar_pkg::CSR_IDX_W-1:0]          index;
   logic [mar_pkg::CSR_DATA_W-1:0]         data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mar_window.sv
// Ring store of conditioned values with running window sum.
module mar_window (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               start,
   input  logic signed [mar_pkg::VAL_W-1:0]   cond,
   input  logic [mar_pkg::WLEN_W-1:0]         wlen,
   output logic signed [mar_pkg::SUM_W-1:0]   sum,
   output logic                               done
);
   import mar_pkg::*;

   logic signed [VAL_W-1:0] mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]   vld_ff;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [IDX_W:0]          pos_nxt;
   logic signed [VAL_W-1:0] cond_ff, rd_ff, old_val;
   logic                    rdv_ff;
   logic                    phase_ff;
   logic                    done_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      old_val = rdv_ff ? rd_ff : '0;
      sum_in  = sum_ff - SUM_W'(old_val) + SUM_W'(cond_ff);
      pos_nxt = {1'b0, pos_ff} + (IDX_W+1)'(1);
      pos_in  = (32'(pos_nxt) >= 32'(wlen)) ? '0 : pos_nxt[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (phase_ff) begin
         mem[pos_ff] <= cond_ff;
      end
      rd_ff <= mem[pos_ff];
      if (start) begin
         cond_ff <= cond;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         rdv_ff   <= 1'b0;
         pos_ff   <= '0;
         sum_ff   <= '0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         rdv_ff   <= vld_ff[pos_ff];
         phase_ff <= start;
         done_ff  <= phase_ff;
         if (clear) begin
            vld_ff <= '0;
            pos_ff <= '0;
            sum_ff <= '0;
         end else if (phase_ff) begin
            vld_ff[pos_ff] <= 1'b1;
            pos_ff         <= pos_in;
            sum_ff         <= sum_in;
         end
      end
   end

   assign sum  = sum_ff;
   assign done = done_ff;

   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < 32'(wlen))
      else $error("ring position outside window");

endmodule

// File: rtl/mar_div.sv
// Serial restoring divider, two quotient bits per cycle.
module mar_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mar_pkg::DIV_W-1:0]     dividend,
   input  logic [mar_pkg::WLEN_W-1:0]    divisor,
   output logic [mar_pkg::DIV_W-1:0]     quotient,
   output logic                          done
);
   import mar_pkg::*;

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [WLEN_W-1:0]    rem_ff, rem_in, den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;

   always_comb begin
      logic [WLEN_W:0]   ra, rb;
      logic [WLEN_W-1:0] rem_a;
      logic              qa, qb;
      ra = {rem_ff, quo_ff[DIV_W-1]};
      qa = (ra >= {1'b0, den_ff});
      if (qa) begin
         ra = ra - {1'b0, den_ff};
      end
      rem_a = ra[WLEN_W-1:0];
      rb = {rem_a, quo_ff[DIV_W-2]};
      qb = (rb >= {1'b0, den_ff});
      if (qb) begin
         rb = rb - {1'b0, den_ff};
      end
      rem_in = rb[WLEN_W-1:0];
      quo_in = {quo_ff[DIV_W-3:0], qa, qb};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: rtl/mar_sqrt.sv
// Serial integer square root, one root bit per cycle.
module mar_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mar_pkg::SQ_IN_W-1:0]   radicand,
   output logic [mar_pkg::SQ_RT_W-1:0]   root,
   output logic                          done
);
   import mar_pkg::*;

   logic [SQ_IN_W-1:0]  rad_ff, rad_in;
   logic [SQ_REM_W-1:0] rem_ff, rem_in;
   logic [SQ_RT_W-1:0]  root_ff, root_in;
   logic [SQ_CNT_W-1:0] cnt_ff;
   logic                busy_ff, done_ff;

   always_comb begin
      logic [SQ_REM_W+1:0] rem_sh, trial;
      rem_sh = {rem_ff, rad_ff[SQ_IN_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      rad_in = {rad_ff[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in  = SQ_REM_W'(rem_sh - trial);
         root_in = {root_ff[SQ_RT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh[SQ_REM_W-1:0];
         root_in = {root_ff[SQ_RT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= SQ_CNT_W'(SQ_RT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - SQ_CNT_W'(1);
            if (cnt_ff == SQ_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// File: rtl/moving_average_abs_rms_core.sv
// Windowed moving average / rms envelope: top level with sequencer and registers.
// Steps per request: window update, divider at two quotient bits per cycle, square root
// at one bit per cycle (rms mode only), output load; rms with a mean of zero or less skips
// the root. A request is accepted only in idle, once the previous result is loaded;
// a stalled response holds the next.
// Reset: window length 100, mode absolute, store valid bits and sum cleared at once.
module moving_average_abs_rms_core (
   input  logic         clock,
   input  logic         reset,
   mar_req_if.sink      req_ch,
   mar_rsp_if.source    rsp_ch,
   mar_csr_if.sink      csr_ch
);
   import mar_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SQRT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [WLEN_W-1:0]   wlen_ff;
   mode_type            mode_ff;
   logic                neg_ff, neg_in;
   logic [OUT_W-1:0]    res_ff, res_in;
   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_value_ff;
   logic                rsp_load;

   logic                req_acc, csr_acc, win_clear;
   logic signed [VAL_W-1:0] ext, sq, cond;
   logic signed [SUM_W-1:0] win_sum;
   logic                win_done;
   logic [SUM_W-1:0]    sum_mag;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_quo;
   logic [OUT_W-1:0]    sat_mag;
   logic                sq_start, sq_done;
   logic [SQ_RT_W-1:0]  sq_root;

   assign req_acc   = req_ch.valid && req_ch.ready;
   assign csr_acc   = csr_ch.valid && csr_ch.ready;
   assign win_clear = csr_acc && (csr_ch.index == REG_WINDOW_LENGTH);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   always_comb begin
      ext = VAL_W'(req_ch.sample);
      sq  = ext * ext;
      case (mode_ff)
         MODE_BIPOLAR:  cond = ext;
         MODE_ABSOLUTE: cond = ext[VAL_W-1] ? -ext : ext;
         MODE_RMS:      cond = sq;
         default:       cond = ext;
      endcase
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= WLEN_W'(RESET_WLEN);
         mode_ff <= MODE_ABSOLUTE;
      end else if (csr_acc) begin
         if (csr_ch.index == REG_WINDOW_LENGTH) begin
            if (csr_ch.data == '0) begin
               wlen_ff <= WLEN_W'(1);
            end else if (32'(csr_ch.data) > 32'(MAX_WINDOW)) begin
               wlen_ff <= WLEN_W'(MAX_WINDOW);
            end else begin
               wlen_ff <= WLEN_W'(csr_ch.data);
            end
         end else if (csr_ch.index == REG_AVERAGE_MODE) begin
            if (csr_ch.data[MODE_W-1:0] == MODE_BIPOLAR ||
                csr_ch.data[MODE_W-1:0] == MODE_ABSOLUTE ||
                csr_ch.data[MODE_W-1:0] == MODE_RMS) begin
               mode_ff <= mode_type'(csr_ch.data[MODE_W-1:0]);
            end
         end
      end
   end

   mar_window u_window (
      .clock (clock),
      .reset (reset),
      .clear (win_clear),
      .start (req_acc),
      .cond  (cond),
      .wlen  (wlen_ff),
      .sum   (win_sum),
      .done  (win_done)
   );

   assign sum_mag = win_sum[SUM_W-1] ? SUM_W'(-win_sum) : SUM_W'(win_sum);

   mar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_W'(sum_mag)),
      .divisor  (wlen_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   mar_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (div_quo[SQ_IN_W-1:0]),
      .root     (sq_root),
      .done     (sq_done)
   );

   assign sat_mag = (div_quo > DIV_W'(OUT_LIMIT)) ? OUT_W'(OUT_LIMIT) : div_quo[OUT_W-1:0];

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      sq_start  = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (win_done) begin
               neg_in    = win_sum[SUM_W-1];
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (mode_ff == MODE_RMS) begin
                  if (neg_ff || div_quo == '0) begin
                     res_in   = '0;
                     state_in = ST_OUT;
                  end else begin
                     sq_start = 1'b1;
                     state_in = ST_SQRT;
                  end
               end else begin
                  res_in   = neg_ff ? -sat_mag : sat_mag;
                  state_in = ST_OUT;
               end
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               res_in   = OUT_W'(sq_root);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_value_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.average_value = rsp_value_ff;

   a_sum_after_request: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##2 win_done)
      else $error("window sum not ready two cycles after request");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   a_rms_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_load && mode_ff == MODE_RMS |-> !res_ff[OUT_W-1])
      else $error("negative rms result");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!res_ff[OUT_W-1] && res_ff <= OUT_W'(OUT_LIMIT)) ||
                   (res_ff[OUT_W-1] && res_ff >= OUT_W'(-OUT_LIMIT)))
      else $error("result outside saturation range");

endmodule
